// ===== hdl/prt_pkg.sv =====
// ============================================================================
// prt_pkg: shared types and constants of the pose retargeting block
// Field widths, function and register codes, and the request and response
// structures of the serial multiplier and the serial root/divide unit.
// ============================================================================
package prt_pkg;

    localparam int POS_W      = 24;
    localparam int ROT_W      = 16;
    localparam int FUNC_W     = 2;
    localparam int IN_DATA_W  = 144;
    localparam int OUT_DATA_W = 136;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 24;
    localparam int RADIUS_W   = 23;

    localparam logic [RADIUS_W-1:0]          RADIUS_RESET = 23'd850000;
    localparam logic signed [POS_W-1:0]      FLOOR_RESET  = 24'sd50000;
    localparam logic signed [ROT_W-1:0]      QONE         = 16'sd16384;

    localparam logic [FUNC_W-1:0] FN_HAND   = 2'd0;
    localparam logic [FUNC_W-1:0] FN_ROBOT  = 2'd1;
    localparam logic [FUNC_W-1:0] FN_SYNC   = 2'd2;
    localparam logic [FUNC_W-1:0] FN_STREAM = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR  = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    // Serial multiplier: magnitudes only, the caller applies the sign.
    localparam int MUL_A_W     = 36;
    localparam int MUL_B_W     = 32;
    localparam int MUL_P_W     = MUL_A_W + MUL_B_W;
    localparam int MUL_DIGIT_W = 4;

    typedef struct packed {
        logic               start;
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic               done;
        logic [MUL_P_W-1:0] prod;
    } mul_rsp_t;

    // Serial root/divide unit.
    localparam int RD_W       = 64;
    localparam int RD_RES_W   = 32;
    localparam int QUO_BITS   = 26;
    localparam int SQRT_STEPS = 32;

    typedef enum logic {
        RD_SQRT = 1'b0,
        RD_DIV  = 1'b1
    } rd_op_t;

    typedef struct packed {
        logic                start;
        rd_op_t              op;
        logic [RD_W-1:0]     num;
        logic [RD_RES_W-1:0] den;
    } rd_req_t;

    typedef struct packed {
        logic                done;
        logic [RD_RES_W-1:0] res;
    } rd_rsp_t;

endpackage

// ===== hdl/prt_mul.sv =====
// ============================================================================
// prt_mul: digit-serial unsigned multiplier
// Consumes the second operand one digit per cycle from the low end and stops
// as soon as the remaining digits are all zero.
// ============================================================================
module prt_mul #(
    parameter int DIGIT_W = prt_pkg::MUL_DIGIT_W
) (
    input  logic              clk,
    input  logic              rst_n,
    input  prt_pkg::mul_req_t req,
    output prt_pkg::mul_rsp_t rsp
);
    import prt_pkg::*;

    logic               busy_reg;
    logic               done_reg;
    logic [MUL_P_W-1:0] a_reg;
    logic [MUL_B_W-1:0] b_reg;
    logic [MUL_P_W-1:0] acc_reg;
    logic [MUL_P_W-1:0] acc_next;
    logic               last;

    always_comb
    begin
        acc_next = acc_reg + MUL_P_W'(a_reg * b_reg[DIGIT_W-1:0]);
        last     = (b_reg >> DIGIT_W) == '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg && last)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b1;
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg   <= MUL_P_W'(req.a);
            b_reg   <= req.b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            a_reg   <= a_reg << DIGIT_W;
            b_reg   <= b_reg >> DIGIT_W;
            acc_reg <= acc_next;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.prod = acc_reg;

endmodule

// ===== hdl/prt_rdiv.sv =====
// ============================================================================
// prt_rdiv: bit-serial square root and divider
// One root bit or one quotient bit per cycle through a shared subtractor.
// ============================================================================
module prt_rdiv (
    input  logic             clk,
    input  logic             rst_n,
    input  prt_pkg::rd_req_t req,
    output prt_pkg::rd_rsp_t rsp
);
    import prt_pkg::*;

    localparam int CNT_W = $clog2(SQRT_STEPS);

    logic             busy_reg;
    logic             done_reg;
    rd_op_t           op_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [RD_W-1:0]  rem_reg;
    logic [RD_W-1:0]  res_reg;
    logic [RD_W-1:0]  bit_reg;
    logic [RD_W-1:0]  trial;
    logic [RD_W-1:0]  rem_next;
    logic [RD_W-1:0]  res_next;
    logic [RD_W-1:0]  bit_next;
    logic             ge;
    logic             last;

    always_comb
    begin
        trial    = (op_reg == RD_SQRT) ? res_reg + bit_reg : bit_reg;
        ge       = rem_reg >= trial;
        rem_next = ge ? rem_reg - trial : rem_reg;
        if (op_reg == RD_SQRT)
        begin
            res_next = ge ? (res_reg >> 1) + bit_reg : res_reg >> 1;
            bit_next = bit_reg >> 2;
            last     = cnt_reg == CNT_W'(SQRT_STEPS - 1);
        end
        else
        begin
            res_next = {res_reg[RD_W-2:0], ge};
            bit_next = bit_reg >> 1;
            last     = cnt_reg == CNT_W'(QUO_BITS - 1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= RD_SQRT;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= req.op;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (last)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= req.num;
            res_reg <= '0;
            if (req.op == RD_SQRT)
                bit_reg <= RD_W'(1) << (RD_W - 2);
            else
                bit_reg <= RD_W'(req.den) << (QUO_BITS - 1);
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            res_reg <= res_next;
            bit_reg <= bit_next;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.res  = res_reg[RD_RES_W-1:0];

endmodule

// ===== hdl/pose_retarget_with_workspace_clamp.sv =====
// ============================================================================
// pose_retarget_with_workspace_clamp: hand pose to robot target retargeting
// Robot pose, sync, streaming and idle hand words are taken in the idle state
//   and give no result word; a sync failure goes to the output state. A
//   streamed hand pose is worked by the 4-bit digit-serial multiplier (40
//   products, 43 when the sphere clamp applies) and the bit-serial
//   root/divider, then waits until the previous result word is taken.
// Throughput: one word at a time; s_tready is high only while idle.
// Reset (rst_n, asynchronous): registers to defaults, identity rotations.
// ============================================================================
module pose_retarget_with_workspace_clamp #(
    parameter int DIGIT_W = prt_pkg::MUL_DIGIT_W
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [prt_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [prt_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // pos_x, pos_y, pos_z, rot_w, rot_x, rot_y, rot_z, enable, zero pad
    input  logic [prt_pkg::IN_DATA_W-1:0]      s_tdata,
    // func
    input  logic [prt_pkg::FUNC_W-1:0]         s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // target_x, target_y, target_z, target_w, target_qx, target_qy, target_qz
    output logic [prt_pkg::OUT_DATA_W-1:0]     m_tdata,
    // status
    output logic [0:0]                         m_tuser
);
    import prt_pkg::*;

    // The sequencer walks the position path first, then the two quaternion
    // products, the norm and the per-component division.
    typedef enum logic [9:0] {
        ST_IDLE  = 10'b0000000001,
        ST_PSQ   = 10'b0000000010,
        ST_PROOT = 10'b0000000100,
        ST_PSCL  = 10'b0000001000,
        ST_REL   = 10'b0000010000,
        ST_TQ    = 10'b0000100000,
        ST_NSQ   = 10'b0001000000,
        ST_NROOT = 10'b0010000000,
        ST_QDIV  = 10'b0100000000,
        ST_OUT   = 10'b1000000000
    } state_t;

    state_t state_reg;
    logic [1:0] idx_reg;
    logic [1:0] jdx_reg;
    logic       wait_reg;
    logic       phase_reg;
    logic       fail_reg;

    logic [RADIUS_W-1:0]     radius_reg;
    logic signed [POS_W-1:0] floor_reg;
    logic                    seen_reg;
    logic                    sync_reg;
    logic                    stream_reg;

    logic signed [POS_W-1:0] rpos_reg [3];
    logic signed [ROT_W-1:0] rrot_reg [4];
    logic signed [24:0]      off_reg  [3];
    logic signed [ROT_W-1:0] base_reg [4];
    logic signed [16:0]      conj_reg [4];

    logic signed [POS_W-1:0] p_reg  [3];
    logic signed [ROT_W-1:0] h_reg  [4];
    logic signed [34:0]      rel_reg[4];
    logic signed [31:0]      c_reg  [4];
    logic signed [POS_W-1:0] tpos_reg[3];
    logic signed [ROT_W-1:0] tq_reg [4];
    logic signed [63:0]      acc_reg;
    logic [63:0]             s_reg;
    logic [63:0]             num_reg;
    logic [RD_RES_W-1:0]     root_reg;

    logic                    m_tvalid_reg;
    logic [OUT_DATA_W-1:0]   m_tdata_reg;
    logic                    m_tuser_reg;

    logic signed [POS_W-1:0] in_p [3];
    logic signed [ROT_W-1:0] in_h [4];
    logic                    in_en;
    logic                    accept;
    logic                    hand_go;
    logic                    hand_fail;

    logic signed [25:0] pos_w   [3];
    logic [25:0]        pos_mag [3];
    logic [15:0]        h_mag   [4];
    logic [16:0]        conj_mag[4];
    logic [34:0]        rel_mag [4];
    logic [15:0]        base_mag[4];
    logic [31:0]        c_mag   [4];

    mul_req_t mul_req;
    mul_rsp_t mul_rsp;
    rd_req_t  rd_req;
    rd_rsp_t  rd_rsp;

    logic               neg_w;
    logic [63:0]        prod64;
    logic signed [63:0] acc_next;
    logic [63:0]        acc_mag;
    logic [63:0]        s_next;
    logic signed [31:0] c_round;
    logic signed [33:0] quo_s;
    logic               out_load;

    function automatic logic qneg(input logic [1:0] k, input logic [1:0] j);
        logic r;
        case (k)
            2'd0:    r = j != 2'd0;
            2'd1:    r = j == 2'd3;
            2'd2:    r = j == 2'd1;
            default: r = j == 2'd2;
        endcase
        return r;
    endfunction

    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [33:0] v);
        logic signed [POS_W-1:0] r;
        if (v > 34'sd8388607)
            r = 24'sh7FFFFF;
        else if (v < -34'sd8388608)
            r = 24'sh800000;
        else
            r = POS_W'(v);
        return r;
    endfunction

    function automatic logic signed [ROT_W-1:0] sat_rot(input logic signed [33:0] v);
        logic signed [ROT_W-1:0] r;
        if (v > 34'sd16384)
            r = QONE;
        else if (v < -34'sd16384)
            r = -QONE;
        else
            r = ROT_W'(v);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Input unpacking and the hand word decision.
    // ------------------------------------------------------------------
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            in_p[i] = s_tdata[POS_W*i +: POS_W];
        for (int i = 0; i < 4; i++)
            in_h[i] = s_tdata[3*POS_W + ROT_W*i +: ROT_W];
        in_en = s_tdata[3*POS_W + 4*ROT_W];
    end

    assign s_tready  = state_reg == ST_IDLE;
    assign accept    = s_tvalid && s_tready;
    // A pending sync takes precedence over streaming; it fails when no robot
    // pose has been seen yet.
    assign hand_fail = accept && s_tuser == FN_HAND && sync_reg && !seen_reg;
    assign hand_go   = accept && s_tuser == FN_HAND && stream_reg && !hand_fail;

    // ------------------------------------------------------------------
    // Position after offset and floor, and the magnitudes fed to the
    // multiplier. The multiplier works on magnitudes; signs are tracked here.
    // ------------------------------------------------------------------
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            pos_w[i] = 26'(p_reg[i]) + 26'(off_reg[i]);
        if (pos_w[2] < 26'(floor_reg))
            pos_w[2] = 26'(floor_reg);
        for (int i = 0; i < 3; i++)
            pos_mag[i] = pos_w[i][25] ? 26'(-pos_w[i]) : 26'(pos_w[i]);
        for (int i = 0; i < 4; i++)
        begin
            h_mag[i]    = h_reg[i][15] ? 16'(-h_reg[i]) : 16'(h_reg[i]);
            conj_mag[i] = conj_reg[i][16] ? 17'(-conj_reg[i]) : 17'(conj_reg[i]);
            rel_mag[i]  = rel_reg[i][34] ? 35'(-rel_reg[i]) : 35'(rel_reg[i]);
            base_mag[i] = base_reg[i][15] ? 16'(-base_reg[i]) : 16'(base_reg[i]);
            c_mag[i]    = c_reg[i][31] ? 32'(-c_reg[i]) : 32'(c_reg[i]);
        end
    end

    // ------------------------------------------------------------------
    // Operand selection for the shared units.
    // ------------------------------------------------------------------
    always_comb
    begin
        mul_req = '0;
        neg_w   = 1'b0;
        case (state_reg)
            ST_PSQ:
            begin
                if (idx_reg == 2'd3)
                begin
                    mul_req.a = MUL_A_W'(radius_reg);
                    mul_req.b = MUL_B_W'(radius_reg);
                end
                else
                begin
                    mul_req.a = MUL_A_W'(pos_mag[idx_reg]);
                    mul_req.b = MUL_B_W'(pos_mag[idx_reg]);
                end
            end
            ST_PSCL:
            begin
                mul_req.a = MUL_A_W'(pos_mag[idx_reg]);
                mul_req.b = MUL_B_W'(radius_reg);
            end
            ST_REL:
            begin
                mul_req.a = MUL_A_W'(conj_mag[idx_reg ^ jdx_reg]);
                mul_req.b = MUL_B_W'(h_mag[jdx_reg]);
                neg_w     = qneg(idx_reg, jdx_reg) ^ conj_reg[idx_reg ^ jdx_reg][16]
                            ^ h_reg[jdx_reg][15];
            end
            ST_TQ:
            begin
                mul_req.a = MUL_A_W'(rel_mag[idx_reg ^ jdx_reg]);
                mul_req.b = MUL_B_W'(base_mag[jdx_reg]);
                neg_w     = qneg(idx_reg, jdx_reg) ^ rel_reg[idx_reg ^ jdx_reg][34]
                            ^ base_reg[jdx_reg][15];
            end
            ST_NSQ:
            begin
                mul_req.a = MUL_A_W'(c_mag[idx_reg]);
                mul_req.b = MUL_B_W'(c_mag[idx_reg]);
            end
            default:
            begin
                mul_req.a = '0;
            end
        endcase
        mul_req.start = !wait_reg && (state_reg == ST_PSQ || state_reg == ST_REL
                        || state_reg == ST_TQ || state_reg == ST_NSQ
                        || (state_reg == ST_PSCL && !phase_reg));
    end

    always_comb
    begin
        rd_req = '0;
        case (state_reg)
            ST_PROOT:
            begin
                rd_req.op  = RD_SQRT;
                rd_req.num = s_reg << 8;
            end
            ST_PSCL:
            begin
                rd_req.op  = RD_DIV;
                rd_req.num = num_reg;
                rd_req.den = root_reg;
            end
            ST_NROOT:
            begin
                rd_req.op  = RD_SQRT;
                rd_req.num = s_reg;
            end
            ST_QDIV:
            begin
                rd_req.op  = RD_DIV;
                rd_req.num = (64'(c_mag[idx_reg]) << 14) + 64'(root_reg >> 1);
                rd_req.den = root_reg;
            end
            default:
            begin
                rd_req.op = RD_SQRT;
            end
        endcase
        rd_req.start = !wait_reg && (state_reg == ST_PROOT || state_reg == ST_NROOT
                       || state_reg == ST_QDIV || (state_reg == ST_PSCL && phase_reg));
    end

    prt_mul #(
        .DIGIT_W (DIGIT_W)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    prt_rdiv u_rdiv (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (rd_req),
        .rsp   (rd_rsp)
    );

    // ------------------------------------------------------------------
    // Accumulation and rounding of unit results.
    // ------------------------------------------------------------------
    always_comb
    begin
        prod64   = mul_rsp.prod[63:0];
        acc_next = neg_w ? acc_reg - $signed(prod64) : acc_reg + $signed(prod64);
        s_next   = s_reg + prod64;
        // Drop twenty fraction bits, rounding half away from zero.
        acc_mag  = acc_next[63] ? 64'(-acc_next) : 64'(acc_next);
        c_round  = 32'((acc_mag + 64'd524288) >> 20);
        if (acc_next[63])
            c_round = -c_round;
        quo_s = $signed({2'b00, rd_rsp.res});
        if ((state_reg == ST_PSCL && pos_w[idx_reg][25])
            || (state_reg == ST_QDIV && c_reg[idx_reg][31]))
            quo_s = -quo_s;
        out_load = state_reg == ST_OUT && (!m_tvalid_reg || m_tready);
    end

    // ------------------------------------------------------------------
    // Control, configuration and retargeting state.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            idx_reg      <= '0;
            jdx_reg      <= '0;
            wait_reg     <= 1'b0;
            phase_reg    <= 1'b0;
            fail_reg     <= 1'b0;
            radius_reg   <= RADIUS_RESET;
            floor_reg    <= FLOOR_RESET;
            seen_reg     <= 1'b0;
            sync_reg     <= 1'b0;
            stream_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                rpos_reg[i] <= '0;
                off_reg[i]  <= '0;
            end
            for (int i = 0; i < 4; i++)
            begin
                rrot_reg[i] <= (i == 0) ? QONE : '0;
                base_reg[i] <= (i == 0) ? QONE : '0;
                conj_reg[i] <= (i == 0) ? 17'(QONE) : '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    CFG_RADIUS: radius_reg <= cfg_data[RADIUS_W-1:0];
                    CFG_FLOOR:  floor_reg  <= $signed(cfg_data);
                    default:    floor_reg  <= floor_reg;
                endcase
            end

            if (mul_req.start || rd_req.start)
                wait_reg <= 1'b1;
            else if (mul_rsp.done || rd_rsp.done)
                wait_reg <= 1'b0;

            if (m_tready && !out_load)
                m_tvalid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        case (s_tuser)
                            FN_ROBOT:
                            begin
                                for (int i = 0; i < 3; i++)
                                    rpos_reg[i] <= in_p[i];
                                for (int i = 0; i < 4; i++)
                                    rrot_reg[i] <= in_h[i];
                                seen_reg <= 1'b1;
                            end
                            FN_SYNC:
                            begin
                                sync_reg <= 1'b1;
                            end
                            FN_STREAM:
                            begin
                                stream_reg <= in_en;
                            end
                            default:
                            begin
                                if (hand_fail)
                                begin
                                    sync_reg   <= 1'b0;
                                    stream_reg <= 1'b0;
                                    fail_reg   <= 1'b1;
                                    state_reg  <= ST_OUT;
                                end
                                else if (sync_reg)
                                begin
                                    // Zeroing: capture offsets against this hand pose.
                                    for (int i = 0; i < 3; i++)
                                        off_reg[i] <= 25'(rpos_reg[i]) - 25'(in_p[i]);
                                    for (int i = 0; i < 4; i++)
                                    begin
                                        base_reg[i] <= rrot_reg[i];
                                        conj_reg[i] <= (i == 0) ? 17'(in_h[i])
                                                                : -17'(in_h[i]);
                                    end
                                    sync_reg <= 1'b0;
                                end
                                if (hand_go)
                                begin
                                    state_reg <= ST_PSQ;
                                    idx_reg   <= '0;
                                    jdx_reg   <= '0;
                                end
                            end
                        endcase
                    end
                end
                ST_PSQ:
                begin
                    if (mul_rsp.done)
                    begin
                        if (idx_reg == 2'd3)
                        begin
                            idx_reg   <= '0;
                            state_reg <= (s_reg > prod64) ? ST_PROOT : ST_REL;
                        end
                        else
                        begin
                            idx_reg <= idx_reg + 1'b1;
                        end
                    end
                end
                ST_PROOT:
                begin
                    if (rd_rsp.done)
                    begin
                        state_reg <= ST_PSCL;
                        phase_reg <= 1'b0;
                    end
                end
                ST_PSCL:
                begin
                    if (mul_rsp.done)
                        phase_reg <= 1'b1;
                    if (rd_rsp.done)
                    begin
                        phase_reg <= 1'b0;
                        if (idx_reg == 2'd2)
                        begin
                            idx_reg   <= '0;
                            state_reg <= ST_REL;
                        end
                        else
                        begin
                            idx_reg <= idx_reg + 1'b1;
                        end
                    end
                end
                ST_REL, ST_TQ:
                begin
                    if (mul_rsp.done)
                    begin
                        jdx_reg <= jdx_reg + 1'b1;
                        if (jdx_reg == 2'd3)
                        begin
                            idx_reg <= idx_reg + 1'b1;
                            if (idx_reg == 2'd3)
                                state_reg <= (state_reg == ST_REL) ? ST_TQ : ST_NSQ;
                        end
                    end
                end
                ST_NSQ:
                begin
                    if (mul_rsp.done)
                    begin
                        idx_reg <= idx_reg + 1'b1;
                        if (idx_reg == 2'd3)
                            state_reg <= ST_NROOT;
                    end
                end
                ST_NROOT:
                begin
                    if (rd_rsp.done)
                        state_reg <= (rd_rsp.res == '0) ? ST_OUT : ST_QDIV;
                end
                ST_QDIV:
                begin
                    if (rd_rsp.done)
                    begin
                        idx_reg <= idx_reg + 1'b1;
                        if (idx_reg == 2'd3)
                            state_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (out_load)
                    begin
                        m_tvalid_reg <= 1'b1;
                        fail_reg     <= 1'b0;
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers.
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (hand_go)
        begin
            for (int i = 0; i < 3; i++)
                p_reg[i] <= in_p[i];
            for (int i = 0; i < 4; i++)
                h_reg[i] <= in_h[i];
            s_reg   <= '0;
            acc_reg <= '0;
        end

        case (state_reg)
            ST_PSQ:
            begin
                if (mul_rsp.done)
                begin
                    if (idx_reg != 2'd3)
                        s_reg <= s_next;
                    else if (s_reg <= prod64)
                        for (int i = 0; i < 3; i++)
                            tpos_reg[i] <= sat_pos(34'(pos_w[i]));
                end
            end
            ST_PROOT:
            begin
                if (rd_rsp.done)
                    root_reg <= rd_rsp.res;
            end
            ST_PSCL:
            begin
                if (mul_rsp.done)
                    num_reg <= (prod64 << 4) + 64'(root_reg >> 1);
                if (rd_rsp.done)
                    tpos_reg[idx_reg] <= sat_pos(quo_s);
            end
            ST_REL:
            begin
                if (mul_rsp.done)
                begin
                    if (jdx_reg == 2'd3)
                    begin
                        rel_reg[idx_reg] <= 35'(acc_next);
                        acc_reg          <= '0;
                    end
                    else
                    begin
                        acc_reg <= acc_next;
                    end
                end
            end
            ST_TQ:
            begin
                if (mul_rsp.done)
                begin
                    if (jdx_reg == 2'd3)
                    begin
                        c_reg[idx_reg] <= c_round;
                        acc_reg        <= '0;
                        s_reg          <= '0;
                    end
                    else
                    begin
                        acc_reg <= acc_next;
                    end
                end
            end
            ST_NSQ:
            begin
                if (mul_rsp.done)
                    s_reg <= s_next;
            end
            ST_NROOT:
            begin
                if (rd_rsp.done)
                begin
                    root_reg <= rd_rsp.res;
                    // A zero norm gives the identity rotation.
                    for (int i = 0; i < 4; i++)
                        tq_reg[i] <= (i == 0) ? QONE : '0;
                end
            end
            ST_QDIV:
            begin
                if (rd_rsp.done)
                    tq_reg[idx_reg] <= sat_rot(quo_s);
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    m_tuser_reg <= fail_reg ? STATUS_FAIL : STATUS_OK;
                    if (fail_reg)
                    begin
                        m_tdata_reg <= '0;
                    end
                    else
                    begin
                        for (int i = 0; i < 3; i++)
                            m_tdata_reg[POS_W*i +: POS_W] <= tpos_reg[i];
                        for (int i = 0; i < 4; i++)
                            m_tdata_reg[3*POS_W + ROT_W*i +: ROT_W] <= tq_reg[i];
                    end
                end
            end
            default:
            begin
                num_reg <= num_reg;
            end
        endcase
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == ST_OUT))
        else $error("result word raised outside the output state");

    a_mul_awaited: assert property (@(posedge clk) disable iff (!rst_n)
        mul_rsp.done |-> wait_reg)
        else $error("product returned without an outstanding request");

    a_rdiv_awaited: assert property (@(posedge clk) disable iff (!rst_n)
        rd_rsp.done |-> wait_reg)
        else $error("root or quotient returned without an outstanding request");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0] == STATUS_FAIL) |-> m_tdata == '0)
        else $error("sync failure word carries non-zero target data");

endmodule
